>>> rtl/tcs_pkg.sv
package tcs_pkg;

  localparam int unsigned COLS_DEF = 80;
  localparam int unsigned ROWS_DEF = 25;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
  localparam logic [CHAR_W-1:0] DEL_CHAR   = 8'd127;
  localparam logic [CHAR_W-1:0] LF_CHAR    = 8'h0A;
  localparam logic [CHAR_W-1:0] CR_CHAR    = 8'h0D;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_ACCESS,
    ST_SCROLL,
    ST_RESP
  } tcs_state_e;

endpackage

>>> rtl/tcs_if.sv
interface tcs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [tcs_pkg::CHAR_W-1:0]  char_code;
  logic [tcs_pkg::ROW_W-1:0]   read_row;
  logic [tcs_pkg::COL_W-1:0]   read_col;

  modport source (output valid, kind, char_code, read_row, read_col, input ready);
  modport sink (input valid, kind, char_code, read_row, read_col, output ready);
endinterface

interface tcs_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcs_pkg::ROW_W-1:0]   cursor_row;
  logic [tcs_pkg::COL_W-1:0]   cursor_col;
  logic [tcs_pkg::CHAR_W-1:0]  cell_char;

  modport source (output valid, cursor_row, cursor_col, cell_char, input ready);
  modport sink (input valid, cursor_row, cursor_col, cell_char, output ready);
endinterface

>>> rtl/tcs_ram.sv
module tcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tcs_ctrl.sv
module tcs_ctrl #(
  parameter int unsigned COLS = tcs_pkg::COLS_DEF,
  parameter int unsigned ROWS = tcs_pkg::ROWS_DEF,
  localparam int unsigned RW = $clog2(ROWS),
  localparam int unsigned CW = $clog2(COLS),
  localparam int unsigned AW = $clog2(ROWS * COLS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_kind_i,
  input  logic [tcs_pkg::CHAR_W-1:0] in_char_i,
  input  logic [tcs_pkg::ROW_W-1:0]  in_row_i,
  input  logic [tcs_pkg::COL_W-1:0]  in_col_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [RW-1:0]              res_row_o,
  output logic [CW-1:0]              res_col_o,
  output logic [tcs_pkg::CHAR_W-1:0] res_cell_o,
  output logic                       mem_we_o,
  output logic                       mem_re_o,
  output logic [AW-1:0]              mem_addr_o,
  output logic [tcs_pkg::CHAR_W-1:0] mem_wdata_o,
  input  logic [tcs_pkg::CHAR_W-1:0] mem_rdata_i
);

  localparam logic [AW-1:0] COLS_A     = AW'(COLS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(ROWS * COLS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLS - 1);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [RW:0]   ROWS_EXT   = (RW + 1)'(ROWS);

  tcs_pkg::tcs_state_e state_q, state_d;

  logic [RW-1:0]              row_q, row_d;
  logic [CW-1:0]              col_q, col_d;
  logic [RW-1:0]              base_q, base_d;
  logic                       kind_q, kind_d;
  logic [tcs_pkg::CHAR_W-1:0] char_q, char_d;
  logic [RW-1:0]              rrow_q, rrow_d;
  logic [CW-1:0]              rcol_q, rcol_d;
  logic                       oob_q, oob_d;
  logic [RW-1:0]              prow_q, prow_d;
  logic [CW-1:0]              tcol_q, tcol_d;
  logic [AW-1:0]              sweep_q, sweep_d;
  logic [CW-1:0]              cnt_q, cnt_d;

  logic          accept;
  logic          printable;
  logic          is_lf;
  logic          is_cr;
  logic          col_last;
  logic          row_last;
  logic          adv_row;
  logic          scroll_req;
  logic [RW-1:0] calc_row;
  logic [RW:0]   calc_sum;
  logic [AW-1:0] cell_addr;

  assign accept     = in_valid_i && in_ready_o;
  assign printable  = (char_q >= tcs_pkg::SPACE_CHAR) && (char_q != tcs_pkg::DEL_CHAR);
  assign is_lf      = char_q == tcs_pkg::LF_CHAR;
  assign is_cr      = char_q == tcs_pkg::CR_CHAR;
  assign col_last   = col_q == LAST_COL;
  assign row_last   = row_q == LAST_ROW;
  assign adv_row    = (printable && col_last) || is_lf;
  assign scroll_req = (kind_q == tcs_pkg::KIND_WRITE) && adv_row && row_last;
  assign calc_row   = (kind_q == tcs_pkg::KIND_READ) ? rrow_q : row_q;
  assign calc_sum   = {1'b0, calc_row} + {1'b0, base_q};
  assign cell_addr  = AW'(AW'(prow_q) * COLS_A) + AW'(tcol_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcs_pkg::ST_CLEAR: begin
        if (sweep_q == LAST_CELL) begin
          state_d = tcs_pkg::ST_IDLE;
        end
      end
      tcs_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = tcs_pkg::ST_CALC;
        end
      end
      tcs_pkg::ST_CALC: begin
        state_d = tcs_pkg::ST_ACCESS;
      end
      tcs_pkg::ST_ACCESS: begin
        state_d = scroll_req ? tcs_pkg::ST_SCROLL : tcs_pkg::ST_RESP;
      end
      tcs_pkg::ST_SCROLL: begin
        if (cnt_q == LAST_COL) begin
          state_d = tcs_pkg::ST_RESP;
        end
      end
      tcs_pkg::ST_RESP: begin
        if (res_ready_i) begin
          state_d = tcs_pkg::ST_IDLE;
        end
      end
      default: state_d = tcs_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = cell_addr;
    mem_wdata_o = char_q;
    unique case (state_q) inside
      tcs_pkg::ST_CLEAR, tcs_pkg::ST_SCROLL: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = sweep_q;
        mem_wdata_o = tcs_pkg::SPACE_CHAR;
      end
      tcs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      tcs_pkg::ST_ACCESS: begin
        mem_we_o = (kind_q == tcs_pkg::KIND_WRITE) && printable;
        mem_re_o = (kind_q == tcs_pkg::KIND_READ) && !oob_q;
      end
      tcs_pkg::ST_RESP: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    base_d  = base_q;
    kind_d  = kind_q;
    char_d  = char_q;
    rrow_d  = rrow_q;
    rcol_d  = rcol_q;
    oob_d   = oob_q;
    prow_d  = prow_q;
    tcol_d  = tcol_q;
    sweep_d = sweep_q;
    cnt_d   = cnt_q;
    case (state_q)
      tcs_pkg::ST_CLEAR: begin
        sweep_d = sweep_q + AW'(1);
      end
      tcs_pkg::ST_IDLE: begin
        if (accept) begin
          kind_d = in_kind_i;
          char_d = in_char_i;
          rrow_d = RW'(in_row_i);
          rcol_d = CW'(in_col_i);
          oob_d  = (32'(in_row_i) >= ROWS) || (32'(in_col_i) >= COLS);
        end
      end
      tcs_pkg::ST_CALC: begin
        prow_d = (calc_sum >= ROWS_EXT) ? RW'(calc_sum - ROWS_EXT) : RW'(calc_sum);
        tcol_d = (kind_q == tcs_pkg::KIND_READ) ? rcol_q : col_q;
      end
      tcs_pkg::ST_ACCESS: begin
        if (kind_q == tcs_pkg::KIND_WRITE) begin
          if (printable) begin
            col_d = col_last ? '0 : col_q + CW'(1);
          end else if (is_lf || is_cr) begin
            col_d = '0;
          end
          if (adv_row && !row_last) begin
            row_d = row_q + RW'(1);
          end
          if (scroll_req) begin
            sweep_d = AW'(AW'(base_q) * COLS_A);
            cnt_d   = '0;
            base_d  = (base_q == LAST_ROW) ? '0 : base_q + RW'(1);
          end
        end
      end
      tcs_pkg::ST_SCROLL: begin
        sweep_d = sweep_q + AW'(1);
        cnt_d   = cnt_q + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcs_pkg::ST_CLEAR;
      row_q   <= '0;
      col_q   <= '0;
      base_q  <= '0;
      sweep_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      base_q  <= base_d;
      sweep_q <= sweep_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    char_q <= char_d;
    rrow_q <= rrow_d;
    rcol_q <= rcol_d;
    oob_q  <= oob_d;
    prow_q <= prow_d;
    tcol_q <= tcol_d;
  end

  assign res_row_o  = row_q;
  assign res_col_o  = col_q;
  assign res_cell_o = ((kind_q == tcs_pkg::KIND_READ) && !oob_q) ? mem_rdata_i : '0;

endmodule

>>> rtl/text_console_cursor_scroll_unit.sv
// Character-cell text console of ROWS rows by COLS columns held in one single-port RAM.
// Items are taken one at a time; an ordinary write or read passes through operand
// capture, row mapping, RAM access and result before the next item is accepted, and the
// result sits in an output register so the next item can enter while it waits. Rows are
// kept in circular order behind a base row pointer, so a scroll copies nothing: a line
// feed or a wrap on the bottom row adds a pass that blanks the recycled row. After reset
// the block fills the RAM with spaces and takes no item until that pass has finished.
module text_console_cursor_scroll_unit #(
  parameter int unsigned COLS = tcs_pkg::COLS_DEF,
  parameter int unsigned ROWS = tcs_pkg::ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcs_in_if.sink     in_i,
  tcs_out_if.source  out_o
);

  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned AW    = $clog2(CELLS);

  logic                       res_valid;
  logic                       res_ready;
  logic [RW-1:0]              res_row;
  logic [CW-1:0]              res_col;
  logic [tcs_pkg::CHAR_W-1:0] res_cell;
  logic                       mem_we;
  logic                       mem_re;
  logic [AW-1:0]              mem_addr;
  logic [tcs_pkg::CHAR_W-1:0] mem_wdata;
  logic [tcs_pkg::CHAR_W-1:0] mem_rdata;

  logic                       out_valid_q;
  logic [tcs_pkg::ROW_W-1:0]  out_row_q;
  logic [tcs_pkg::COL_W-1:0]  out_col_q;
  logic [tcs_pkg::CHAR_W-1:0] out_cell_q;

  tcs_ctrl #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_kind_i   (in_i.kind),
    .in_char_i   (in_i.char_code),
    .in_row_i    (in_i.read_row),
    .in_col_i    (in_i.read_col),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_row_o   (res_row),
    .res_col_o   (res_col),
    .res_cell_o  (res_cell),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  tcs_ram #(
    .WIDTH(tcs_pkg::CHAR_W),
    .DEPTH(CELLS)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_row_q  <= tcs_pkg::ROW_W'(res_row);
      out_col_q  <= tcs_pkg::COL_W'(res_col);
      out_cell_q <= res_cell;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cursor_row = out_row_q;
  assign out_o.cursor_col = out_col_q;
  assign out_o.cell_char  = out_cell_q;

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("Second item accepted while one is in progress.");

  a_ram_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("Screen RAM read and written in the same cycle.");

  a_ram_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we || mem_re |-> 32'(mem_addr) < CELLS)
    else $error("Screen RAM address beyond the screen.");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (32'(res_row) < ROWS) && (32'(res_col) < COLS))
    else $error("Cursor outside the screen.");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned N_ROWS          = tcs_pkg::ROWS_DEF;
  localparam int unsigned N_COLS          = tcs_pkg::COLS_DEF;
  localparam int unsigned N_RANDOM        = 1780;
  localparam int unsigned HOLD_OFF_AFTER  = 600;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 2 * N_COLS + 20;
  localparam int unsigned IDLE_LIMIT      = 4 * N_ROWS * N_COLS;

  typedef struct packed {
    logic                       kind;
    logic [tcs_pkg::CHAR_W-1:0] char_code;
    logic [tcs_pkg::ROW_W-1:0]  read_row;
    logic [tcs_pkg::COL_W-1:0]  read_col;
  } console_op_t;

  typedef struct packed {
    logic [tcs_pkg::ROW_W-1:0]  cursor_row;
    logic [tcs_pkg::COL_W-1:0]  cursor_col;
    logic [tcs_pkg::CHAR_W-1:0] cell_char;
  } console_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #4 clk_i = ~clk_i;

  tcs_in_if  in_if ();
  tcs_out_if out_if ();

  text_console_cursor_scroll_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [tcs_pkg::CHAR_W-1:0] screen_model [N_ROWS][N_COLS];
  int unsigned                cur_row;
  int unsigned                cur_col;

  console_op_t    pending_q [$];
  console_reply_t expected_q [$];

  int unsigned n_items;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_writes;
  int unsigned n_reads;
  int unsigned n_off_screen;
  int unsigned n_scrolls;

  function automatic void scroll_screen();
    for (int r = 0; r < N_ROWS - 1; r++) begin
      screen_model[r] = screen_model[r+1];
    end
    for (int c = 0; c < N_COLS; c++) begin
      screen_model[N_ROWS-1][c] = tcs_pkg::SPACE_CHAR;
    end
    n_scrolls++;
  endfunction

  function automatic console_reply_t console_predict(console_op_t op);
    console_reply_t rep;
    rep = '0;
    if (op.kind == tcs_pkg::KIND_WRITE) begin
      if (op.char_code >= tcs_pkg::SPACE_CHAR && op.char_code != tcs_pkg::DEL_CHAR) begin
        screen_model[cur_row][cur_col] = op.char_code;
        cur_col++;
      end else if (op.char_code == tcs_pkg::LF_CHAR) begin
        cur_row++;
        cur_col = 0;
      end else if (op.char_code == tcs_pkg::CR_CHAR) begin
        cur_col = 0;
      end
      if (cur_col >= N_COLS) begin
        cur_row++;
        cur_col = 0;
      end
      while (cur_row >= N_ROWS) begin
        scroll_screen();
        cur_row--;
      end
      n_writes++;
    end else begin
      if (op.read_row < N_ROWS && op.read_col < N_COLS) begin
        rep.cell_char = screen_model[op.read_row][op.read_col];
      end else begin
        n_off_screen++;
      end
      n_reads++;
    end
    rep.cursor_row = tcs_pkg::ROW_W'(cur_row);
    rep.cursor_col = tcs_pkg::COL_W'(cur_col);
    return rep;
  endfunction

  function automatic void push_write(logic [tcs_pkg::CHAR_W-1:0] code);
    console_op_t op;
    op = '0;
    op.kind = tcs_pkg::KIND_WRITE;
    op.char_code = code;
    pending_q.push_back(op);
  endfunction

  function automatic void push_read(int unsigned row, int unsigned col);
    console_op_t op;
    op = '0;
    op.kind = tcs_pkg::KIND_READ;
    op.read_row = tcs_pkg::ROW_W'(row);
    op.read_col = tcs_pkg::COL_W'(col);
    pending_q.push_back(op);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  int unsigned gap_left;
  int unsigned n_sent;

  always @(posedge clk_i or negedge rst_ni) begin
    console_op_t op;
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.kind      <= tcs_pkg::KIND_WRITE;
      in_if.char_code <= '0;
      in_if.read_row  <= '0;
      in_if.read_col  <= '0;
      gap_left        <= 0;
      n_sent          <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0) begin
        in_if.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (pending_q.size() != 0) begin
        op = pending_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.kind      <= op.kind;
        in_if.char_code <= op.char_code;
        in_if.read_row  <= op.read_row;
        in_if.read_col  <= op.read_col;
        n_sent          <= n_sent + 1;
        gap_left        <= ((n_sent / 150) % 4 == 3) ? 0 : pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  int unsigned stall_left;
  bit          hold_off_done;
  int unsigned rx_cycle;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready  <= 1'b0;
      stall_left    <= 0;
      hold_off_done <= 1'b0;
      rx_cycle      <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (!hold_off_done && n_checked >= HOLD_OFF_AFTER) begin
        out_if.ready  <= 1'b0;
        stall_left    <= HOLD_OFF_CYCLES - 1;
        hold_off_done <= 1'b1;
      end else if ((rx_cycle / 500) % 4 == 2 || $urandom_range(99) < 65) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        stall_left   <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    console_reply_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no item pending: cursor_row %0d cursor_col %0d cell_char %0d",
                 out_if.cursor_row, out_if.cursor_col, out_if.cell_char);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_if.cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, actual %0d", want.cursor_row, out_if.cursor_row);
            n_errors++;
          end
          if (out_if.cursor_col !== want.cursor_col) begin
            $error("cursor_col: expected %0d, actual %0d", want.cursor_col, out_if.cursor_col);
            n_errors++;
          end
          if (out_if.cell_char !== want.cell_char) begin
            $error("cell_char: expected %0d, actual %0d", want.cell_char, out_if.cell_char);
            n_errors++;
          end
          n_checked <= n_checked + 1;
        end
      end
      if (in_if.valid && in_if.ready) begin
        expected_q.push_back(console_predict({in_if.kind, in_if.char_code,
                                              in_if.read_row, in_if.read_col}));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned sel;
    int unsigned pick;
    in_if.valid     = 1'b0;
    in_if.kind      = tcs_pkg::KIND_WRITE;
    in_if.char_code = '0;
    in_if.read_row  = '0;
    in_if.read_col  = '0;
    out_if.ready    = 1'b0;
    rst_ni          = 1'b0;
    n_accepted      = 0;
    n_checked       = 0;
    n_errors        = 0;
    n_writes        = 0;
    n_reads         = 0;
    n_off_screen    = 0;
    n_scrolls       = 0;
    idle_cycles     = 0;
    cur_row         = 0;
    cur_col         = 0;
    for (int r = 0; r < N_ROWS; r++) begin
      for (int c = 0; c < N_COLS; c++) begin
        screen_model[r][c] = tcs_pkg::SPACE_CHAR;
      end
    end

    // Control bytes other than line feed and carriage return must leave everything alone.
    push_read(0, 0);
    push_write(8'h48);
    push_write(8'd255);
    push_write(8'd128);
    push_write(8'd126);
    push_write(tcs_pkg::SPACE_CHAR);
    push_write(8'd0);
    push_write(8'd31);
    push_write(tcs_pkg::DEL_CHAR);
    push_write(8'h0B);
    push_write(tcs_pkg::CR_CHAR);
    push_read(0, 0);
    push_read(0, 1);
    push_read(0, 4);
    push_write(tcs_pkg::LF_CHAR);
    push_read(N_ROWS - 1, N_COLS - 1);
    push_read(N_ROWS, 0);
    push_read(31, 127);
    push_read(0, N_COLS);
    push_read(0, 127);
    push_read(N_ROWS - 1, 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        pick = $urandom_range(99);
        if (pick < 60) push_write(tcs_pkg::CHAR_W'($urandom_range(32, 126)));
        else if (pick < 72) push_write(tcs_pkg::CHAR_W'($urandom_range(128, 255)));
        else if (pick < 82) push_write(tcs_pkg::LF_CHAR);
        else if (pick < 87) push_write(tcs_pkg::CR_CHAR);
        else push_write(tcs_pkg::CHAR_W'($urandom_range(0, 255)));
      end else if (sel < 93) begin
        push_read($urandom_range(0, N_ROWS - 1), $urandom_range(0, N_COLS - 1));
      end else begin
        push_read($urandom_range(0, 31), $urandom_range(0, 127));
      end
    end
    n_items = pending_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_items) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results: %0d writes with %0d scrolls, %0d reads (%0d off screen).",
             n_checked, n_writes, n_scrolls, n_reads, n_off_screen);
    $display("The output side held off for %0d cycles once while items kept arriving.",
             HOLD_OFF_CYCLES);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
